>>> hdl/sirc_pkg.sv
// ----------------------------------------------------------------------------
// sirc_pkg: shared definitions for the signed integer to radix text converter
// Holds default sizes, register indexes, character codes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sirc_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;  // default input width
  localparam int unsigned MAX_BASE       = 16;  // cap on the alphabet length
  localparam int unsigned SYM_W          = 8;   // one text byte
  localparam int unsigned DIGIT_W        = 4;   // one digit value, radix <= 16
  localparam int unsigned ALPHA_N        = 16;  // symbol slots in the alphabet
  localparam int unsigned RADIX_W        = 5;   // radix_length register width
  localparam int unsigned CFG_DATA_W     = 64;  // widest register
  localparam int unsigned CFG_IDX_W      = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  // Character codes
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_DEL   = 8'h7F;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture a new value, clear the digit count
    logic div_en;    // run one division step group
    logic div_last;  // final group of a division: store the digit
    logic ptr_load;  // point at the most significant digit
    logic ptr_dec;   // advance to the next lower digit
    logic out_load;  // fill the output register
    logic out_sign;  // output byte is the minus sign
  } sirc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic alpha_ok;   // alphabet passes every check
    logic neg;        // captured value is negative
    logic quot_zero;  // quotient of the current division is zero
    logic ptr_zero;   // digit pointer at the least significant digit
    logic can_load;   // output register free or being emptied
  } sirc_stat_t;

endpackage

>>> hdl/sirc_if.sv
// ----------------------------------------------------------------------------
// sirc_if: stream channels of the radix text converter
// Input channel carries one signed value per item, output channel one text
// byte with its end-of-number flag per item.
// ----------------------------------------------------------------------------
interface sirc_in_if import sirc_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sirc_out_if import sirc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

>>> hdl/sirc_datapath.sv
// ----------------------------------------------------------------------------
// sirc_datapath: registers, alphabet check, divider and digit store
// Divides the magnitude by the radix a few bits per cycle, keeps the digits
// in a small memory and feeds them, top digit first, to the output register.
// ----------------------------------------------------------------------------
module sirc_datapath import sirc_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned DIV_STEP   = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  sirc_cmd_t                    cmd,
  output sirc_stat_t                   stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [SYM_W-1:0]             out_symbol,
  output logic                         out_last
);

  localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned ADDR_W = $clog2(VALUE_BITS);

  logic [RADIX_W-1:0]          radix_len_r;
  logic [CFG_DATA_W-1:0]       sym_lo_r;
  logic [CFG_DATA_W-1:0]       sym_hi_r;
  logic [ALPHA_N*SYM_W-1:0]    alpha;
  logic [RADIX_W-1:0]          radix_use;
  logic                        alpha_ok;

  logic [VALUE_BITS-1:0]       value_u;
  logic [VALUE_BITS-1:0]       mag;
  logic [VALUE_BITS-1:0]       sh_r;
  logic [DIGIT_W-1:0]          rem_r;
  logic                        neg_r;
  logic [VALUE_BITS-1:0]       div_sh;
  logic [DIGIT_W-1:0]          div_rem;

  logic [CNT_W-1:0]            count_r;
  logic [ADDR_W-1:0]           ptr_r;
  logic [ADDR_W-1:0]           ptr_nxt;
  logic [DIGIT_W-1:0]          digit_mem [VALUE_BITS];
  logic [DIGIT_W-1:0]          rd_data_r;

  logic                        out_valid_r;
  logic [SYM_W-1:0]            out_symbol_r;
  logic                        out_last_r;
  logic                        can_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_len_r <= '0;
      sym_lo_r    <= '0;
      sym_hi_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIX_LENGTH: radix_len_r <= cfg_data[RADIX_W-1:0];
        CFG_SYMBOLS_LOW:  sym_lo_r    <= cfg_data;
        CFG_SYMBOLS_HIGH: sym_hi_r    <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign alpha     = {sym_hi_r, sym_lo_r};
  assign radix_use = (radix_len_r > RADIX_W'(MAX_BASE)) ? RADIX_W'(MAX_BASE) : radix_len_r;

  // Alphabet check: two or more symbols, printable, no space or sign characters, no duplicates
  always_comb begin
    logic [SYM_W-1:0] c;
    alpha_ok = (radix_use >= RADIX_W'(2));
    for (int i = 0; i < ALPHA_N; i++) begin
      c = alpha[i*SYM_W +: SYM_W];
      if (RADIX_W'(i) < radix_use) begin
        if (c == CH_PLUS || c == CH_MINUS || c <= CH_SPACE || c >= CH_DEL) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < ALPHA_N; j++) begin
          if (RADIX_W'(j) < radix_use && alpha[j*SYM_W +: SYM_W] == c) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // Magnitude as unsigned, so the most negative value needs no extra bit
  assign value_u = in_value;
  assign mag     = value_u[VALUE_BITS-1] ? (VALUE_BITS'(0) - value_u) : value_u;

  // Restoring division, DIV_STEP quotient bits per cycle
  always_comb begin
    logic [DIGIT_W:0]        p;
    logic [DIGIT_W-1:0]      rem_v;
    logic [VALUE_BITS-1:0]   sh_v;
    rem_v = rem_r;
    sh_v  = sh_r;
    for (int k = 0; k < DIV_STEP; k++) begin
      p    = {rem_v, sh_v[VALUE_BITS-1]};
      sh_v = {sh_v[VALUE_BITS-2:0], 1'b0};
      if (p >= (DIGIT_W+1)'(radix_use)) begin
        rem_v   = DIGIT_W'(p - (DIGIT_W+1)'(radix_use));
        sh_v[0] = 1'b1;
      end else begin
        rem_v = p[DIGIT_W-1:0];
      end
    end
    div_sh  = sh_v;
    div_rem = rem_v;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sh_r  <= mag;
      rem_r <= '0;
      neg_r <= value_u[VALUE_BITS-1];
    end else if (cmd.div_en) begin
      sh_r  <= div_sh;
      rem_r <= cmd.div_last ? '0 : div_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
    end else begin
      if (cmd.load) begin
        count_r <= '0;
      end else if (cmd.div_last) begin
        count_r <= count_r + CNT_W'(1);
      end
      ptr_r <= ptr_nxt;
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_load) begin
      ptr_nxt = ADDR_W'(count_r - CNT_W'(1));
    end else if (cmd.ptr_dec) begin
      ptr_nxt = ptr_r - ADDR_W'(1);
    end
  end

  // Digit store: least significant digit at address 0
  always_ff @(posedge clk) begin
    if (cmd.div_last) begin
      digit_mem[count_r[ADDR_W-1:0]] <= div_rem;
    end
    rd_data_r <= digit_mem[ptr_nxt];
  end

  // Output register
  assign can_load = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_symbol_r <= cmd.out_sign ? CH_MINUS : alpha[rd_data_r*SYM_W +: SYM_W];
      out_last_r   <= !cmd.out_sign && (ptr_r == '0);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

  assign stat.alpha_ok  = alpha_ok;
  assign stat.neg       = neg_r;
  assign stat.quot_zero = (div_sh == '0);
  assign stat.ptr_zero  = (ptr_r == '0);
  assign stat.can_load  = can_load;

  // Never overwrite a byte the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while full");

  // Digit count stays within the store
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_last |-> (count_r < CNT_W'(VALUE_BITS)))
    else $error("digit store overflow");

endmodule

>>> hdl/sirc_ctrl.sv
// ----------------------------------------------------------------------------
// sirc_ctrl: sequencer of the radix text converter
// Accepts a value, checks the alphabet (dropping the value if it fails), runs
// one division per digit, then sends any minus sign and the digits to the output register.
// ----------------------------------------------------------------------------
module sirc_ctrl import sirc_pkg::*; #(
  parameter int unsigned DIV_STEPS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sirc_stat_t stat,
  output sirc_cmd_t  cmd
);

  localparam int unsigned STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_PREP  = 3'd3;
  localparam logic [2:0] ST_SIGN  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = '0;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = stat.alpha_ok ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        if (step_r == STEP_LAST) begin
          cmd.div_last = 1'b1;
          if (stat.quot_zero) begin
            state_nxt = ST_PREP;
          end
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_PREP: begin
        cmd.ptr_load = 1'b1;
        state_nxt    = stat.neg ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (stat.can_load) begin
          cmd.out_load = 1'b1;
          cmd.out_sign = 1'b1;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.can_load) begin
          cmd.out_load = 1'b1;
          if (stat.ptr_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.ptr_dec = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CHECK))
    else $error("accepted item not followed by the alphabet check");

  a_next_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_r == STEP_LAST && !stat.quot_zero)
      |=> (state_r == ST_DIV && step_r == '0))
    else $error("nonzero quotient did not start another digit");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && stat.can_load && stat.ptr_zero) |=> (state_r == ST_IDLE))
    else $error("final digit sent but sequencer still busy");

endmodule

>>> hdl/signed_int_to_custom_radix_digits.sv
// ----------------------------------------------------------------------------
// signed_int_to_custom_radix_digits: signed integer to text in a set radix
// Renders each input value as a minus sign when negative, then its digits,
// most significant first, drawn from a configured alphabet.
// ----------------------------------------------------------------------------
// Usage
//   in_stream  : one signed VALUE_BITS-wide value per item (valid/ready).
//   out_stream : one text byte per item, last marks the final byte of a number.
//   cfg_*      : write radix_length (0), symbols_low (1), symbols_high (2)
//                while the block is idle; other indexes are ignored.
//   An invalid alphabet (under two symbols, a duplicate, '+', '-', space,
//   control or non-ASCII bytes) makes the value produce no bytes at all.
// Division and flow
//   The divider retires DIV_STEP quotient bits per cycle, one division per
//   digit. One value is worked on at a time; in_stream.ready is high only when
//   idle.
// Reset and stalls
//   Reset clears the configuration to zero (radix 0, so input is dropped until
//   configured). A stalled receiver holds the output register; the sequencer
//   waits with it, and the last byte of a number may still wait while the
//   next value is accepted.
// ----------------------------------------------------------------------------
module signed_int_to_custom_radix_digits import sirc_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sirc_in_if.sink               in_stream,
  sirc_out_if.source            out_stream,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Largest divider group of at most eight bits that splits VALUE_BITS evenly
  localparam int unsigned DIV_STEP =
    (VALUE_BITS % 8 == 0) ? 8 :
    (VALUE_BITS % 7 == 0) ? 7 :
    (VALUE_BITS % 6 == 0) ? 6 :
    (VALUE_BITS % 5 == 0) ? 5 :
    (VALUE_BITS % 4 == 0) ? 4 :
    (VALUE_BITS % 3 == 0) ? 3 :
    (VALUE_BITS % 2 == 0) ? 2 : 1;
  localparam int unsigned DIV_STEPS = VALUE_BITS / DIV_STEP;

  sirc_cmd_t  cmd;
  sirc_stat_t stat;

  // Sequencer: owns the input handshake
  sirc_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_stream.valid),
    .in_ready (in_stream.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: registers, divider, digit store and output register
  sirc_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .DIV_STEP   (DIV_STEP)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_value   (in_stream.value),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_stream.valid),
    .out_ready  (out_stream.ready),
    .out_symbol (out_stream.symbol),
    .out_last   (out_stream.last)
  );

endmodule
